FILE: rtl/core/bra_pkg.sv
// shared types, sequencer program and control codes for the rational approximation block
package bra_pkg;

   localparam int MaxStepsDefault = 65536;
   localparam int FracBitsDefault = 32;
   localparam int InBits          = 48;
   localparam int IntBits         = 17;
   localparam int NumBits         = 32;
   localparam int TolBits         = 32;
   localparam int RspDataBits     = 88;
   localparam logic [TolBits-1:0] TolReset = 32'd1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_INIT,
      OP_STEP,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NO_REQ,
      COND_TRIVIAL,
      COND_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic [2:0] {
      STEP_WAIT,
      STEP_INIT,
      STEP_SEARCH,
      STEP_EMIT,
      STEP_BACK
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic trivial;
      logic more;
   } status_type;

   // jump taken when cond holds, otherwise fall through to the next step
   function automatic ctrl_type bra_rom(step_type pc);
      ctrl_type w;
      unique case (pc)
         STEP_WAIT:   w = '{OP_LOAD, COND_NO_REQ,   STEP_WAIT};
         STEP_INIT:   w = '{OP_INIT, COND_TRIVIAL,  STEP_EMIT};
         STEP_SEARCH: w = '{OP_STEP, COND_MORE,     STEP_SEARCH};
         STEP_EMIT:   w = '{OP_EMIT, COND_OUT_BUSY, STEP_EMIT};
         STEP_BACK:   w = '{OP_NONE, COND_ALWAYS,   STEP_WAIT};
         default:     w = '{OP_NONE, COND_ALWAYS,   STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/bra_datapath.sv
// datapath of the mediant search: bounds, error terms, step count and tolerance register
module bra_datapath
   import bra_pkg::*;
#(
   parameter int MAX_STEPS = MaxStepsDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  op_type              op,
   input  logic                csr_wr_en,
   input  logic [TolBits-1:0]  csr_wr_data,
   input  logic [InBits-1:0]   x_value,
   output status_type          status,
   output logic [IntBits-1:0]  int_part,
   output logic [NumBits-1:0]  numerator,
   output logic [NumBits-1:0]  denominator,
   output logic                stopped
);

   localparam int DW = FRAC_BITS + 34;
   localparam int SW = $clog2(MAX_STEPS + 1);
   localparam logic signed [DW-1:0] OneD = DW'(1) << FRAC_BITS;

   logic [TolBits-1:0]         tolerance_ff, tolerance_in;
   logic [FRAC_BITS-1:0]       f_ff, f_in;
   logic [IntBits-1:0]         ip_ff, ip_in;
   logic [NumBits-1:0]         ln_ff, ln_in, ld_ff, ld_in, un_ff, un_in, ud_ff, ud_in;
   logic [NumBits-1:0]         mn_ff, mn_in, md_ff, md_in;
   logic signed [DW-1:0]       da_lo_ff, da_lo_in, db_lo_ff, db_lo_in;
   logic signed [DW-1:0]       da_up_ff, da_up_in, db_up_ff, db_up_in;
   logic [SW-1:0]              steps_ff, steps_in;
   logic                       stopped_ff, stopped_in;

   logic [FRAC_BITS+TolBits-1:0] tol_ext;
   logic [FRAC_BITS-1:0]       e;
   logic [FRAC_BITS:0]         fpe, fme;
   logic                       near_zero, near_one;
   logic [NumBits:0]           nd;
   logic signed [DW-1:0]       da_m, db_m;
   logic                       halt, go_lower, go_higher;
   logic signed [InBits-1:0]   x_shifted;

   // tolerance aligned to the fraction width
   assign tol_ext = {tolerance_ff, FRAC_BITS'(0)};
   assign e       = tol_ext[FRAC_BITS+TolBits-1:TolBits];

   assign fpe       = {1'b0, f_ff} + {1'b0, e};
   assign fme       = {1'b0, f_ff} - {1'b0, e};
   assign near_zero = f_ff < e;
   assign near_one  = fpe > {1'b1, FRAC_BITS'(0)};

   assign nd        = {1'b0, ld_ff} + {1'b0, ud_ff};
   assign da_m      = da_lo_ff + da_up_ff;
   assign db_m      = db_lo_ff + db_up_ff;
   assign halt      = (steps_ff >= SW'(MAX_STEPS)) || nd[NumBits];
   assign go_lower  = da_m[DW-1];
   assign go_higher = !go_lower && !db_m[DW-1] && (db_m != '0);

   assign x_shifted = $signed(x_value) >>> FRAC_BITS;

   assign status.trivial = near_zero || near_one;
   assign status.more    = !halt && (go_lower || go_higher);

   always_comb begin
      tolerance_in = csr_wr_en ? csr_wr_data : tolerance_ff;
      f_in       = f_ff;
      ip_in      = ip_ff;
      ln_in      = ln_ff;
      ld_in      = ld_ff;
      un_in      = un_ff;
      ud_in      = ud_ff;
      mn_in      = mn_ff;
      md_in      = md_ff;
      da_lo_in   = da_lo_ff;
      db_lo_in   = db_lo_ff;
      da_up_in   = da_up_ff;
      db_up_in   = db_up_ff;
      steps_in   = steps_ff;
      stopped_in = stopped_ff;
      unique case (op)
         OP_LOAD: begin
            f_in  = x_value[FRAC_BITS-1:0];
            ip_in = x_shifted[IntBits-1:0];
         end
         OP_INIT: begin
            if (!near_zero && near_one) begin
               ip_in = ip_ff + IntBits'(1);
            end
            ln_in      = '0;
            ld_in      = NumBits'(1);
            un_in      = NumBits'(1);
            ud_in      = NumBits'(1);
            mn_in      = '0;
            md_in      = NumBits'(1);
            da_lo_in   = DW'(fpe);
            db_lo_in   = DW'(fme);
            da_up_in   = DW'(fpe) - OneD;
            db_up_in   = DW'(fme) - OneD;
            steps_in   = '0;
            stopped_in = 1'b0;
         end
         OP_STEP: begin
            if (halt) begin
               stopped_in = 1'b1;
            end else begin
               mn_in    = ln_ff + un_ff;
               md_in    = nd[NumBits-1:0];
               steps_in = steps_ff + SW'(1);
               if (go_lower) begin
                  un_in    = ln_ff + un_ff;
                  ud_in    = nd[NumBits-1:0];
                  da_up_in = da_m;
                  db_up_in = db_m;
               end else if (go_higher) begin
                  ln_in    = ln_ff + un_ff;
                  ld_in    = nd[NumBits-1:0];
                  da_lo_in = da_m;
                  db_lo_in = db_m;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TolReset;
      end else begin
         tolerance_ff <= tolerance_in;
      end
      f_ff       <= f_in;
      ip_ff      <= ip_in;
      ln_ff      <= ln_in;
      ld_ff      <= ld_in;
      un_ff      <= un_in;
      ud_ff      <= ud_in;
      mn_ff      <= mn_in;
      md_ff      <= md_in;
      da_lo_ff   <= da_lo_in;
      db_lo_ff   <= db_lo_in;
      da_up_ff   <= da_up_in;
      db_up_ff   <= db_up_in;
      steps_ff   <= steps_in;
      stopped_ff <= stopped_in;
   end

   assign int_part    = ip_ff;
   assign numerator   = mn_ff;
   assign denominator = md_ff;
   assign stopped     = stopped_ff;

endmodule

FILE: rtl/core/best_rational_approximation.sv
// top level: microcoded sequencer, output register and the search datapath
//
//  channel   dir  port group    payload (lowest bit first)
//  req       in   req_tdata     x_value[47:0]
//  rsp       out  rsp_tdata     int_part[16:0], numerator[48:17], denominator[80:49], zero pad
//  rsp       out  rsp_tuser     stopped
//  csr       in   csr_wr_*      tolerance[31:0]
//
//  a beat goes through the wait, init, emit and back steps; unless the fraction is near 0 or 1,
//  the search step between init and emit repeats for each mediant tested, until a mediant
//  lies within tolerance or the step cap or denominator overflow ends the search
//  reset returns tolerance to 1, the sequencer to its wait step, no result pending
//  a result waits in the output register while the next beat is taken; the sequencer
//  holds at its emit step only while that register is still occupied
module best_rational_approximation
   import bra_pkg::*;
#(
   parameter int MAX_STEPS = MaxStepsDefault,
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [InBits-1:0]      req_tdata,    // x_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RspDataBits-1:0] rsp_tdata,    // int_part, numerator, denominator, pad
   output logic                   rsp_tuser,    // stopped
   input  logic                   csr_wr_en,
   input  logic [TolBits-1:0]     csr_wr_data   // tolerance
);

   step_type                pc_ff, pc_in;
   ctrl_type                ctrl;
   op_type                  dp_op;
   status_type              status;
   logic                    cond_true;
   logic                    out_busy;
   logic                    out_load;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RspDataBits-1:0]  rsp_tdata_ff, rsp_tdata_in;
   logic                    rsp_tuser_ff, rsp_tuser_in;
   logic [IntBits-1:0]      int_part;
   logic [NumBits-1:0]      numerator, denominator;
   logic                    stopped;

   assign ctrl     = bra_rom(pc_ff);
   assign out_busy = rsp_tvalid_ff && !rsp_tready;
   assign out_load = (ctrl.op == OP_EMIT) && !out_busy;

   assign req_tready = (ctrl.op == OP_LOAD);
   assign dp_op      = ((ctrl.op == OP_LOAD) && !req_tvalid) ? OP_NONE : ctrl.op;

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NO_REQ:   cond_true = !req_tvalid;
         COND_TRIVIAL:  cond_true = status.trivial;
         COND_MORE:     cond_true = status.more;
         COND_OUT_BUSY: cond_true = out_busy;
         default:       cond_true = 1'b1;
      endcase
   end

   bra_datapath #(
      .MAX_STEPS (MAX_STEPS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .op          (dp_op),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .x_value     (req_tdata),
      .status      (status),
      .int_part    (int_part),
      .numerator   (numerator),
      .denominator (denominator),
      .stopped     (stopped)
   );

   always_comb begin
      pc_in         = cond_true ? ctrl.target : step_type'(pc_ff + 3'd1);
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      if (out_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = RspDataBits'({denominator, numerator, int_part});
         rsp_tuser_in  = stopped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_WAIT;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   a_accept_starts_init: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (pc_ff == STEP_INIT))
      else $error("accepted beat did not start the init step");

   a_denominator_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[80:49] != '0))
      else $error("result denominator is zero");

   a_stopped_has_mediant: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[48:17] != '0))
      else $error("stopped result without a tested mediant");

   a_load_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> ($past(pc_ff) == STEP_EMIT))
      else $error("result register loaded outside the emit step");

endmodule

FILE: bench/tb.sv
// testbench for best_rational_approximation: streams fixed-point values, checks each result
module tb;
   import bra_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FracBits   = FracBitsDefault;
   localparam int MaxSteps   = MaxStepsDefault;
   localparam int HoldCycles = 400;
   localparam int StallLimit = 4 * (MaxSteps + 40) + 4 * HoldCycles;

   typedef struct packed {
      logic [IntBits-1:0] int_part;
      logic [NumBits-1:0] num;
      logic [NumBits-1:0] den;
      logic               stopped;
   } approx_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [InBits-1:0]      req_tdata = '0;      // x_value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;           // int_part, numerator, denominator, pad
   logic                   rsp_tuser;           // stopped
   logic                   csr_wr_en = 1'b0;
   logic [TolBits-1:0]     csr_wr_data = '0;    // tolerance

   logic [InBits-1:0]  values_to_send[$];
   approx_t            approx_due[$];
   logic [TolBits-1:0] model_tol = TolReset;
   logic [TolBits-1:0] tol_now = TolReset;
   bit                 req_taken = 1'b0;
   bit                 idle_on = 1'b1;
   int                 values_queued = 0;
   int                 inputs_taken = 0;
   int                 results_seen = 0;
   int                 near_integer = 0;
   int                 cut_short = 0;
   int                 settings = 1;
   int                 errors = 0;
   int                 send_gap = 0;
   int                 stall_left = 0;
   int                 hold_left = 0;
   int                 hold_asks = 0;
   int                 hold_seen = 0;
   int                 quiet = 0;

   best_rational_approximation dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // floor, near-integer tests, then mediant search between 0/1 and 1/1
   function automatic approx_t approximate(logic [InBits-1:0] x, logic [TolBits-1:0] tol);
      logic signed [63:0] whole;
      logic [63:0]        frac, err, one, lo_n, lo_d, hi_n, hi_d, med_n, med_d, next_d;
      logic [127:0]       scaled, upper_lim, lower_lim;
      int unsigned        steps;
      bit                 done;
      approx_t            r;
      whole = 64'($signed(x));
      whole = whole >>> FracBits;
      frac = 64'(x[FracBits-1:0]);
      err = (FracBits >= 32) ? 64'(tol) << (FracBits - 32) : 64'(tol) >> (32 - FracBits);
      one = 64'd1 << FracBits;
      lo_n = 0;
      lo_d = 1;
      hi_n = 1;
      hi_d = 1;
      med_n = 0;
      med_d = 1;
      steps = 0;
      r.stopped = 1'b0;
      if (frac < err) begin
         whole = whole;
      end else if (one - err < frac) begin
         whole = whole + 1;
      end else begin
         done = 1'b0;
         while (!done) begin
            next_d = lo_d + hi_d;
            if (steps >= MaxSteps || next_d > 64'hFFFF_FFFF) begin
               r.stopped = 1'b1;
               done = 1'b1;
            end else begin
               med_n = lo_n + hi_n;
               med_d = next_d;
               steps++;
               scaled = 128'(med_n) << FracBits;
               upper_lim = 128'(med_d) * 128'(frac + err);
               lower_lim = 128'(med_d) * 128'(frac - err);
               if (upper_lim < scaled) begin
                  hi_n = med_n;
                  hi_d = med_d;
               end else if (scaled < lower_lim) begin
                  lo_n = med_n;
                  lo_d = med_d;
               end else begin
                  done = 1'b1;
               end
            end
         end
      end
      r.int_part = whole[IntBits-1:0];
      r.num = med_n[NumBits-1:0];
      r.den = med_d[NumBits-1:0];
      return r;
   endfunction

   // mostly plain random fractions, some near an integer, some close to a small ratio
   function automatic logic [InBits-1:0] random_value(logic [TolBits-1:0] tol);
      logic [15:0] whole;
      logic [31:0] frac, span, j;
      logic [63:0] base;
      int unsigned q, p, pick;
      whole = 16'($urandom);
      frac = $urandom;
      pick = $urandom_range(0, 9);
      span = tol[31] ? 32'hFFFF_FFFF : {tol[30:0], 1'b0};
      if (tol != 0) begin
         if (pick == 6) begin
            frac = $urandom_range(0, span);
         end else if (pick == 7) begin
            frac = ~$urandom_range(0, span);
         end else if (pick >= 8) begin
            q = $urandom_range(2, 64);
            p = $urandom_range(1, q - 1);
            j = $urandom_range(0, tol - 1);
            base = (64'(p) << 32) / 64'(q);
            if ($urandom_range(0, 1)) begin
               base = base + 64'(j);
            end else begin
               base = (64'(j) > base) ? 64'd0 : base - 64'(j);
            end
            frac = (base > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : base[31:0];
         end
      end
      return {whole, frac};
   endfunction

   task automatic flag_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic push_value(input logic [InBits-1:0] x);
      values_to_send.push_back(x);
      values_queued++;
   endtask

   task automatic push_random(input int n);
      repeat (n) push_value(random_value(tol_now));
   endtask

   task automatic wait_idle();
      while (inputs_taken != values_queued || approx_due.size() != 0) @(negedge clock);
   endtask

   task automatic new_setting(input logic [TolBits-1:0] tol);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= tol;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tol_now = tol;
      settings++;
      @(posedge clock);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (values_to_send.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 15);
            req_tvalid <= 1'b0;
         end else begin
            req_tdata <= values_to_send.pop_front();
            req_tvalid <= 1'b1;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HoldCycles - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      approx_t want;
      req_taken = !reset && req_tvalid && req_tready;
      if (reset) begin
         model_tol = TolReset;
      end else begin
         if (csr_wr_en) model_tol = csr_wr_data;
         if (req_taken) begin
            want = approximate(req_tdata, model_tol);
            approx_due.push_back(want);
            inputs_taken++;
            if (want.num == 0) near_integer++;
            if (want.stopped) cut_short++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (approx_due.size() == 0) begin
               $display("%0t ns: result with none awaited, expected nothing, got %0h", $time,
                        rsp_tdata);
               errors++;
            end else begin
               want = approx_due.pop_front();
               flag_field("int_part", 64'(want.int_part), 64'(rsp_tdata[16:0]));
               flag_field("numerator", 64'(want.num), 64'(rsp_tdata[48:17]));
               flag_field("denominator", 64'(want.den), 64'(rsp_tdata[80:49]));
               flag_field("stopped", 64'(want.stopped), 64'(rsp_tuser));
            end
         end
      end
   end

   initial begin : watchdog
      while (quiet < StallLimit) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t ns: no beat for %0d cycles", $time, StallLimit);
      $display("tb: errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // tolerance at its reset value
      push_value(48'h0000_0000_0000);
      push_value(48'h7FFF_FFFF_FFFF);
      push_value(48'h8000_0000_0000);
      push_value(48'hFFFF_FFFF_FFFF);
      push_value(48'h0000_8000_0000);
      push_value(48'hFFFF_5555_5555);
      push_value(48'h0003_9E37_79B9);
      push_value(48'h0000_0000_0001);
      push_value(48'h7FFF_FFFF_FFFE);
      push_value(48'hAAAA_AAAA_AAAA);
      push_value(48'h5555_5555_5555);
      push_value(48'hFFFE_C000_0000);
      push_random(140);

      // zero tolerance: exact dyadic hits, overflow and step cap
      new_setting(32'h0000_0000);
      push_value(48'h0000_0000_0000);
      push_value(48'h0000_9E37_79B9);
      push_value(48'h0000_8000_0000);
      push_value(48'h0000_4000_0000);
      push_value(48'hFFFB_C000_0000);
      push_random(60);

      // widest tolerance of this run
      new_setting(32'h8000_0000);
      push_value(48'h0000_8000_0000);
      push_value(48'h0000_7FFF_FFFF);
      push_value(48'h0000_8000_0001);
      push_value(48'h0000_0000_0000);
      push_value(48'hFFFF_FFFF_FFFF);
      push_random(60);

      new_setting($urandom_range(16, 1 << 20));
      hold_asks++;
      push_random(100);

      new_setting($urandom_range(1 << 20, 1 << 30));
      push_random(60);

      // closing stretch without idling
      new_setting($urandom_range(2, 4096));
      idle_on = 1'b0;
      push_random(120);

      wait_idle();
      repeat (256) @(negedge clock);
      $display("run covered %0d values under %0d tolerance settings, %0d results checked",
               inputs_taken, settings, results_seen);
      $display("%0d landed near an integer, %0d searches cut short by cap or overflow",
               near_integer, cut_short);
      if (errors == 0 && approx_due.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
